// ===== sv/lhs_pkg.sv =====
// shared types, constants and reset values for the latency histogram monitor
package lhs_pkg;

	// field widths
	localparam int LAT_W      = 64;
	localparam int VAL_W      = 32;
	localparam int BKT_IDX_W  = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int NUM_BOUNDS = 7;
	localparam int TDATA_W    = 200;

	// default geometry
	localparam int NUM_BUCKETS_DEF = 8;

	// iterative divider: one quotient bit per cycle
	localparam int DIV_STEPS = LAT_W;

	// input operation codes (s_tuser)
	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_REPORT = 1'b1;

	// result kinds (m_tuser)
	localparam logic KIND_SUMMARY = 1'b0;
	localparam logic KIND_BUCKET  = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BOUND_FIRST = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BOUND_LAST  = 3'd6;

	// bound reset values
	typedef logic [VAL_W-1:0] val_t;
	localparam val_t BOUND_RST [NUM_BOUNDS] = '{
		32'd100, 32'd500, 32'd1000, 32'd5000, 32'd10000, 32'd50000, 32'd100000
	};

	// result beat payload, first member in the top bits
	typedef struct packed {
		logic [4:0]           pad;
		val_t                 sample_total;
		val_t                 avg_us;
		val_t                 max_us;
		val_t                 min_us;
		val_t                 bucket_count;
		val_t                 bucket_upper;
		logic [BKT_IDX_W-1:0] bucket_index;
	} out_data_t;

endpackage

// ===== sv/lhs_ram.sv =====
// generic single write port, single read port ram with registered read
module lhs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write, then registered read (old data on a same-address collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/lhs_div.sv =====
// restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit per cycle
module lhs_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [lhs_pkg::LAT_W-1:0] dividend,
	input  logic [lhs_pkg::VAL_W-1:0] divisor,
	output logic                      done,
	output logic [lhs_pkg::VAL_W-1:0] quotient
);

	import lhs_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VAL_W-1:0] rem_q;
	logic [LAT_W-1:0] quo_q;
	logic [VAL_W-1:0] dvs_q;

	logic [VAL_W:0]   shifted;
	logic [VAL_W:0]   diff;
	logic             take;

	// one trial subtract per cycle
	always_comb begin
		shifted = {rem_q, quo_q[LAT_W-1]};
		diff    = shifted - {1'b0, dvs_q};
		take    = (shifted >= {1'b0, dvs_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[VAL_W-1:0] : shifted[VAL_W-1:0];
			quo_q <= {quo_q[LAT_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[VAL_W-1:0];

endmodule

// ===== sv/latency_histogram_stats.sv =====
// latency histogram monitor top level: sample pipeline, bucket store and report sequencer
//
// Input stream s_*: s_tuser[0] is the operation (0 record, 1 report), s_tdata the
// 64-bit latency sample. A record beat is taken every cycle while idle: its bucket
// is chosen by parallel bound compares and the bucket count is read from the bucket ram,
// then incremented from the registered read data and written back, with forwarding of the
// previous write so back-to-back samples into one bucket count correctly.
// A report beat stops intake (s_tready low) until the report run has been taken.
// The average comes from a bit-serial divider, so the summary beat appears once the
// divider has finished; then each bucket beat passes a ram read, a load and a handoff
// that waits out any stall on m_tready. The final bucket beat carries m_tlast. While
// m_tready is low the current result beat holds on the output register and nothing
// new is accepted. Configuration: cfg_* writes bound registers 0..6, always ready; the
// user is to write them only while idle, which the block does not enforce. Reset
// restores default bounds, clears all statistics and marks every bucket entry empty
// through per-entry valid bits, so no clearing pass is needed.
module latency_histogram_stats #(
	parameter int NUM_BUCKETS = lhs_pkg::NUM_BUCKETS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [lhs_pkg::LAT_W-1:0]     s_tdata,   // [63:0] latency
	input  logic [0:0]                    s_tuser,   // [0] operation
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [2:0] bucket_index, [34:3] bucket_upper, [66:35] bucket_count, [98:67] min_us,
	// [130:99] max_us, [162:131] avg_us, [194:163] sample_total, [199:195] zero
	output logic [lhs_pkg::TDATA_W-1:0]   m_tdata,
	output logic [0:0]                    m_tuser,   // [0] kind
	output logic                          m_tlast,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lhs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lhs_pkg::VAL_W-1:0]     cfg_data
);

	import lhs_pkg::*;

	localparam int BW = $clog2(NUM_BUCKETS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SUM,
		ST_BKT_RD,
		ST_BKT_LD,
		ST_BKT_WT
	} state_t;

	state_t          state_q;
	logic [BW-1:0]   idx_q;
	out_data_t       out_q;
	logic            out_vld_q;
	logic            out_kind_q;
	logic            out_last_q;

	val_t            bound_q [NUM_BOUNDS];
	val_t            upper_arr [NUM_BUCKETS];

	logic [VAL_W-1:0] count_q;
	logic [LAT_W-1:0] sum_q;
	val_t             min_q;
	val_t             max_q;

	logic             in_acc;
	logic             rec_acc;
	logic             rpt_acc;
	val_t             sat;
	logic [BW-1:0]    pick;

	logic             vld_s1;
	logic [BW-1:0]    addr_s1;
	logic             last_vld_q;
	logic [BW-1:0]    last_addr_q;
	val_t             last_data_q;
	logic             valid_q [NUM_BUCKETS];

	logic [BW-1:0]    raddr;
	val_t             rdata;
	val_t             cur_cnt;
	val_t             new_cnt;

	logic             div_done;
	val_t             div_quo;

	// handshakes
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;
	assign rec_acc   = in_acc && (s_tuser[0] == OP_RECORD);
	assign rpt_acc   = in_acc && (s_tuser[0] == OP_REPORT);

	// bound registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BOUNDS; i++) begin
				bound_q[i] <= BOUND_RST[i];
			end
		end else if (cfg_valid && cfg_ready && cfg_index <= CFG_BOUND_LAST) begin
			bound_q[cfg_index] <= cfg_data;
		end
	end

	// per-bucket upper bound, last bucket open ended
	always_comb begin
		for (int i = 0; i < NUM_BUCKETS - 1; i++) begin
			upper_arr[i] = bound_q[CFG_IDX_W'(i)];
		end
		upper_arr[NUM_BUCKETS-1] = '1;
	end

	// bucket select: first bound at or above the full sample
	always_comb begin
		pick = BW'(NUM_BUCKETS - 1);
		for (int i = NUM_BUCKETS - 2; i >= 0; i--) begin
			if (s_tdata <= {{(LAT_W-VAL_W){1'b0}}, bound_q[CFG_IDX_W'(i)]}) begin
				pick = BW'(i);
			end
		end
	end

	// sample saturated to 32 bits
	assign sat = (|s_tdata[LAT_W-1:VAL_W]) ? '1 : s_tdata[VAL_W-1:0];

	// scalar statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			min_q   <= '1;
			max_q   <= '0;
		end else if (rec_acc) begin
			count_q <= count_q + 1'b1;
			sum_q   <= sum_q + s_tdata;
			if (sat < min_q) begin
				min_q <= sat;
			end
			if (sat > max_q) begin
				max_q <= sat;
			end
		end
	end

	// bucket ram read address: sample pick while idle, report index otherwise
	assign raddr = (state_q == ST_IDLE) ? pick : idx_q;

	lhs_ram #(
		.WIDTH (VAL_W),
		.DEPTH (NUM_BUCKETS)
	) u_bucket_ram (
		.clk   (clk),
		.we    (vld_s1),
		.waddr (addr_s1),
		.wdata (new_cnt),
		.raddr (raddr),
		.rdata (rdata)
	);

	// increment with forwarding of the previous cycle's write
	always_comb begin
		if (last_vld_q && last_addr_q == addr_s1) begin
			cur_cnt = last_data_q;
		end else if (valid_q[addr_s1]) begin
			cur_cnt = rdata;
		end else begin
			cur_cnt = '0;
		end
		new_cnt = cur_cnt + 1'b1;
	end

	// read-modify-write pipeline control and entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			last_vld_q <= 1'b0;
			for (int i = 0; i < NUM_BUCKETS; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else begin
			vld_s1     <= rec_acc;
			last_vld_q <= vld_s1;
			if (vld_s1) begin
				valid_q[addr_s1] <= 1'b1;
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		addr_s1     <= pick;
		last_addr_q <= addr_s1;
		last_data_q <= new_cnt;
	end

	// average divider
	lhs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rpt_acc),
		.dividend (sum_q),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// report sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			out_vld_q  <= 1'b0;
			out_kind_q <= KIND_SUMMARY;
			out_last_q <= 1'b0;
			out_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (rpt_acc) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						out_q      <= '{
							default:      '0,
							min_us:       (count_q == '0) ? '0 : min_q,
							max_us:       max_q,
							avg_us:       (count_q == '0) ? '0 : div_quo,
							sample_total: count_q
						};
						out_kind_q <= KIND_SUMMARY;
						out_last_q <= 1'b0;
						out_vld_q  <= 1'b1;
						state_q    <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (m_tready) begin
						out_vld_q <= 1'b0;
						idx_q     <= '0;
						state_q   <= ST_BKT_RD;
					end
				end
				ST_BKT_RD: begin
					state_q <= ST_BKT_LD;
				end
				ST_BKT_LD: begin
					out_q      <= '{
						default:      '0,
						bucket_index: BKT_IDX_W'(idx_q),
						bucket_upper: upper_arr[idx_q],
						bucket_count: valid_q[idx_q] ? rdata : '0
					};
					out_kind_q <= KIND_BUCKET;
					out_last_q <= (idx_q == BW'(NUM_BUCKETS - 1));
					out_vld_q  <= 1'b1;
					state_q    <= ST_BKT_WT;
				end
				ST_BKT_WT: begin
					if (m_tready) begin
						out_vld_q <= 1'b0;
						if (idx_q == BW'(NUM_BUCKETS - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_BKT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid   = out_vld_q;
	assign m_tdata    = out_q;
	assign m_tuser[0] = out_kind_q;
	assign m_tlast    = out_last_q;

`ifndef SYNTHESIS
	// no input is taken while a result beat is pending
	a_no_intake_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input accepted while a result beat is pending");

	// bucket reads of a report never overlap a pending count write
	a_no_rmw_during_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BKT_RD) |-> !vld_s1)
		else $error("bucket write in flight during report read");

	// the divider finishes only while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	// the run ends on a bucket beat
	a_last_is_bucket: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tuser[0] == KIND_BUCKET))
		else $error("last mark on a summary beat");

	// a report always starts with the divide step
	a_report_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_acc |=> (state_q == ST_DIV))
		else $error("report did not start the divider");
`endif

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for the latency histogram monitor: stimulus, model and checks
`timescale 1ns / 1ps

// tracks bucket counts and summary statistics, queues the report beats they imply
class hist_tracker;
	typedef struct {
		bit        kind;
		bit [2:0]  bucket_index;
		bit [31:0] bucket_upper;
		bit [31:0] bucket_count;
		bit [31:0] min_us;
		bit [31:0] max_us;
		bit [31:0] avg_us;
		bit [31:0] sample_total;
		bit        last;
	} report_beat_t;

	int            num_buckets;
	bit [31:0]     bounds [lhs_pkg::NUM_BOUNDS];
	bit [31:0]     sample_count;
	bit [63:0]     latency_sum;
	bit [31:0]     min_latency;
	bit [31:0]     max_latency;
	bit [31:0]     bucket_hits [];
	report_beat_t  report_beats_due [$];
	int            mismatches;
	int            beats_checked;

	function new(int nb);
		num_buckets = nb;
		bucket_hits = new[nb];
		foreach (bounds[i]) bounds[i] = lhs_pkg::BOUND_RST[i];
		foreach (bucket_hits[i]) bucket_hits[i] = '0;
		sample_count = '0;
		latency_sum = '0;
		min_latency = '1;
		max_latency = '0;
		mismatches = 0;
		beats_checked = 0;
	endfunction

	// writes to indexes past the last bound are dropped
	function void set_bound(bit [lhs_pkg::CFG_IDX_W-1:0] idx, bit [31:0] value);
		if (idx >= lhs_pkg::CFG_BOUND_FIRST && idx <= lhs_pkg::CFG_BOUND_LAST)
			bounds[idx] = value;
	endfunction

	// the last bucket is open ended
	function bit [31:0] upper_of(int i);
		if (i >= num_buckets - 1)
			return '1;
		return bounds[i];
	endfunction

	function int pending();
		return report_beats_due.size();
	endfunction

	// one accepted input beat: record a sample or queue a full report run
	function void take_item(bit op, bit [63:0] lat);
		bit [31:0]    sat;
		int           b;
		report_beat_t r;
		if (op == lhs_pkg::OP_RECORD) begin
			sat = (lat > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : lat[31:0];
			b = num_buckets - 1;
			for (int i = 0; i < num_buckets - 1; i++) begin
				if (lat <= {32'h0, upper_of(i)}) begin
					b = i;
					break;
				end
			end
			sample_count += 1;
			latency_sum += lat;
			if (sat < min_latency) min_latency = sat;
			if (sat > max_latency) max_latency = sat;
			bucket_hits[b] += 1;
			return;
		end
		// summary beat
		r = '{default: '0};
		r.kind = lhs_pkg::KIND_SUMMARY;
		r.min_us = (sample_count == 0) ? 32'h0 : min_latency;
		r.max_us = max_latency;
		r.avg_us = (sample_count == 0) ? 32'h0 : 32'(latency_sum / {32'h0, sample_count});
		r.sample_total = sample_count;
		report_beats_due.push_back(r);
		// one beat per bucket, last one marked
		for (int i = 0; i < num_buckets; i++) begin
			r = '{default: '0};
			r.kind = lhs_pkg::KIND_BUCKET;
			r.bucket_index = i[2:0];
			r.bucket_upper = upper_of(i);
			r.bucket_count = bucket_hits[i];
			r.last = (i == num_buckets - 1);
			report_beats_due.push_back(r);
		end
	endfunction

	task report_mismatch(string msg);
		if (mismatches < 30)
			$display("mismatch @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task cmp(string name, int beat_no, bit [31:0] got, bit [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("beat %0d %s got 0x%08h want 0x%08h",
				beat_no, name, got, want));
	endtask

	// compare one accepted result beat with the oldest one due
	task check_result(bit kind, lhs_pkg::out_data_t d, bit last);
		report_beat_t w;
		if (report_beats_due.size() == 0) begin
			report_mismatch($sformatf("result beat kind %0d with nothing due", kind));
			return;
		end
		w = report_beats_due.pop_front();
		cmp("kind", beats_checked, kind, w.kind);
		cmp("bucket_index", beats_checked, d.bucket_index, w.bucket_index);
		cmp("bucket_upper", beats_checked, d.bucket_upper, w.bucket_upper);
		cmp("bucket_count", beats_checked, d.bucket_count, w.bucket_count);
		cmp("min_us", beats_checked, d.min_us, w.min_us);
		cmp("max_us", beats_checked, d.max_us, w.max_us);
		cmp("avg_us", beats_checked, d.avg_us, w.avg_us);
		cmp("sample_total", beats_checked, d.sample_total, w.sample_total);
		cmp("last", beats_checked, last, w.last);
		cmp("pad", beats_checked, d.pad, 32'h0);
		beats_checked++;
	endtask
endclass

module tb_top;
	import lhs_pkg::*;

	localparam int NB = NUM_BUCKETS_DEF;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE = 100;
	localparam int NUM_PHASES = 7;
	localparam int PHASE_ITEMS = 60;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [LAT_W-1:0]     s_tdata = '0;
	logic [0:0]           s_tuser = OP_RECORD;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic [0:0]           m_tuser;
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [VAL_W-1:0]     cfg_data = '0;

	hist_tracker stats = new(NB);

	bit idle_on = 1'b1;
	int gap_pct = 25;
	int stall_pct = 25;
	int items_sent = 0;
	int reports_sent = 0;
	int cycles = 0;

	always #2 clk = ~clk;

	latency_histogram_stats #(.NUM_BUCKETS(NB)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d result beats still due",
				cycles, stats.pending());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			stats.check_result(m_tuser[0], m_tdata, m_tlast);
	end

	// receiver back-pressure in random bursts
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 99) < stall_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9) - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// one input beat, with an optional gap ahead of it
	task send_item(input logic op, input logic [LAT_W-1:0] lat);
		int n;
		if (idle_on && $urandom_range(0, 99) < gap_pct) begin
			n = $urandom_range(1, 9);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= lat;
		do @(posedge clk); while (!s_tready);
		stats.take_item(op, lat);
		items_sent++;
		if (op == OP_REPORT) reports_sent++;
	endtask

	task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		stats.set_bound(idx, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drop valid, drain every due beat, then let trailing samples retire
	task settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (stats.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// latency mix: extremes, near current bounds, near the 32-bit saturation point
	function automatic logic [LAT_W-1:0] pick_latency();
		logic [LAT_W-1:0] base;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return {$urandom, $urandom};
			3: return {32'h0, $urandom};
			4, 5, 6: begin
				base = {32'h0, stats.bounds[$urandom_range(0, NUM_BOUNDS - 1)]};
				return base + $urandom_range(0, 4) - 2;
			end
			7: return 64'h0000_0000_FFFF_FFFF + $urandom_range(0, 2) - 1;
			default: return LAT_W'($urandom_range(0, 200000));
		endcase
	endfunction

	// bound settings per phase, extremes among them
	function automatic logic [VAL_W-1:0] phase_bound(int ph, int i);
		case (ph)
			0: return BOUND_RST[i];
			1: return '0;
			2: return '1;
			3: return (i + 1) * $urandom_range(20, 60);
			4: return $urandom;
			5: return (i == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 300000);
			default: return BOUND_RST[i] + $urandom_range(0, 50);
		endcase
	endfunction

	initial begin
		logic [LAT_W-1:0] lat;
		logic             op;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// directed: empty report, bound edges, saturation, sum wrap, same-bucket pairs
		send_item(OP_REPORT, '0);
		send_item(OP_RECORD, 64'd0);
		send_item(OP_RECORD, 64'd100);
		send_item(OP_RECORD, 64'd101);
		send_item(OP_RECORD, 64'd500);
		send_item(OP_RECORD, 64'd100000);
		send_item(OP_RECORD, 64'd100001);
		send_item(OP_REPORT, '1);
		send_item(OP_RECORD, 64'h0000_0000_FFFF_FFFF);
		send_item(OP_RECORD, 64'h0000_0001_0000_0000);
		send_item(OP_RECORD, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(OP_RECORD, 64'h8000_0000_0000_0000);
		send_item(OP_RECORD, 64'd7);
		send_item(OP_RECORD, 64'd7);
		send_item(OP_RECORD, 64'd7);
		send_item(OP_REPORT, 64'h5A5A_5A5A_5A5A_5A5A);
		send_item(OP_REPORT, '0);

		// random phases, each under a fresh set of bounds
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			settle();
			for (int i = CFG_BOUND_FIRST; i <= CFG_BOUND_LAST; i++)
				write_reg(CFG_IDX_W'(i), phase_bound(ph, i));
			write_reg(CFG_UNUSED, $urandom);
			if (ph == NUM_PHASES - 1) begin
				idle_on = 1'b0;
			end else begin
				gap_pct = $urandom_range(0, 40);
				stall_pct = $urandom_range(0, 40);
			end
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				op = ($urandom_range(0, 9) == 0) ? OP_REPORT : OP_RECORD;
				lat = pick_latency();
				send_item(op, lat);
			end
			send_item(OP_REPORT, {$urandom, $urandom});
		end
		settle();

		$display("sent %0d input beats including %0d reports over %0d bound settings",
			items_sent, reports_sent, NUM_PHASES + 1);
		$display("checked %0d result beats, %0d mismatches",
			stats.beats_checked, stats.mismatches);
		if (stats.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
